[hw/rtl/mp3hbp_pkg.sv]
// ----------------------------------------------------------------------------
// mp3hbp_pkg: shared types and constants of the Huffman bit packer
// Input and result payload structs, opcodes and the front-to-back item record.
// ----------------------------------------------------------------------------
`default_nettype none
package mp3hbp_pkg;

	typedef enum logic [2:0] {
		OP_LOAD_CODE  = 3'd0,
		OP_LOAD_VALUE = 3'd1,
		OP_PAIR       = 3'd2,
		OP_QUAD       = 3'd3,
		OP_FLUSH      = 3'd4
	} opcode_t;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [5:0]  table_sel;
		logic [7:0]  entry_index;
		logic [18:0] code_word;
		logic [4:0]  code_length;
		logic [4:0]  table_value;
		logic [13:0] mag_first;
		logic [13:0] mag_second;
		logic [3:0]  quad_nonzero;
		logic [3:0]  sign_bits;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} out_item_t;

	localparam int unsigned MAX_LEN     = 21;
	localparam int unsigned MAX_LINBITS = 13;
	localparam int unsigned ESC_LIMIT   = 14;
	localparam int unsigned ESC_VALUE   = 15;
	localparam int unsigned ESC_ROW     = 16;
	localparam int unsigned QUAD_FIRST  = 32;
	localparam int unsigned QUAD_LAST   = 33;
	// Longest pair: 21 code bits + 2x13 linbits = 47, plus 7 pending
	localparam int unsigned SEG_W = 48;
	localparam int unsigned SEG_N = 6;

	// Classified item handed from the front to the back. The code store
	// read data is joined in the back; the tail holds linbits and sign bits
	// (up to 2x13 linbits plus two signs).
	typedef struct packed {
		logic        flush;
		logic        has_code;
		logic [4:0]  nsign;
		logic [27:0] tail;
		logic [5:0]  tail_n;
	} job_t;

endpackage
`default_nettype wire

[hw/rtl/mp3hbp_front.sv]
// ----------------------------------------------------------------------------
// mp3hbp_front: item classifier
// Takes loads into the stores, and turns pair, quad and flush items into jobs
// (pair and quad items on a table outside their range are dropped); the code
// store read data is registered together with the job in stage 2.
// ----------------------------------------------------------------------------
`default_nettype none
module mp3hbp_front #(
	parameter int unsigned TABLE_SLOTS = 34,
	parameter int unsigned ENTRIES_PER_TABLE = 256
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  mp3hbp_pkg::in_item_t in_data,
	// job into the queue, with registered code store read data
	output logic                 job_valid,
	input  wire                  job_ready,
	output mp3hbp_pkg::job_t     job_data,
	output logic [23:0]          job_code
);
	localparam int unsigned SEL_W = 6;
	localparam int unsigned ADDR_W = $clog2(TABLE_SLOTS * ENTRIES_PER_TABLE);

	logic [23:0] code_mem [TABLE_SLOTS * ENTRIES_PER_TABLE];
	logic [4:0]  tv_mem [TABLE_SLOTS];

	// stage 1: table value read for pair/quad
	logic                 v_s1;
	mp3hbp_pkg::in_item_t d_s1;
	logic [4:0]           tv_s1;
	logic                 adv_s1;
	logic                 v_s2;
	logic                 adv_s2;

	assign adv_s2 = !v_s2 || job_ready;
	assign adv_s1 = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	logic in_range;
	assign in_range = {26'd0, in_data.table_sel} < TABLE_SLOTS;

	// store writes
	always_ff @(posedge clk) begin
		if (in_valid && in_ready && in_range) begin
			if (in_data.opcode == mp3hbp_pkg::OP_LOAD_CODE)
				code_mem[ADDR_W'({in_data.table_sel, in_data.entry_index})] <=
					{in_data.code_length, in_data.code_word};
			if (in_data.opcode == mp3hbp_pkg::OP_LOAD_VALUE)
				tv_mem[in_data.table_sel[SEL_W-1:0]] <= in_data.table_value;
		end
	end

	logic take;
	always_comb begin
		take = 1'b0;
		if (in_data.opcode == mp3hbp_pkg::OP_PAIR)
			take = in_data.table_sel != 6'd0 && in_data.table_sel <= 6'd31 && in_range;
		if (in_data.opcode == mp3hbp_pkg::OP_QUAD)
			take = (in_data.table_sel == 6'(mp3hbp_pkg::QUAD_FIRST) ||
				in_data.table_sel == 6'(mp3hbp_pkg::QUAD_LAST)) && in_range;
		if (in_data.opcode == mp3hbp_pkg::OP_FLUSH)
			take = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= in_valid && take;
		end
	end
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			d_s1 <= in_data;
			tv_s1 <= tv_mem[in_data.table_sel[SEL_W-1:0]];
		end
	end

	// stage 1 classification: entry index, tail bits
	logic [4:0]  tv, lin;
	logic [13:0] x, y;
	logic        bx, by, ex, ey;
	logic [13:0] xe, ye;
	logic [3:0]  cx, cy;
	logic [7:0]  entry;
	logic [12:0] rowprod;
	logic [2:0]  qn;
	mp3hbp_pkg::job_t job;
	logic [3:0]  qs;
	logic [2:0]  qsn;

	always_comb begin
		tv = tv_s1;
		x = d_s1.mag_first;
		y = d_s1.mag_second;
		bx = x != 14'd0;
		by = y != 14'd0;
		ex = d_s1.table_sel >= 6'd16 && x > 14'(mp3hbp_pkg::ESC_LIMIT);
		ey = d_s1.table_sel >= 6'd16 && y > 14'(mp3hbp_pkg::ESC_LIMIT);
		lin = (tv > 5'(mp3hbp_pkg::MAX_LINBITS)) ? 5'(mp3hbp_pkg::MAX_LINBITS) : tv;
		xe = x - 14'(mp3hbp_pkg::ESC_VALUE);
		ye = y - 14'(mp3hbp_pkg::ESC_VALUE);
		cx = ex ? 4'(mp3hbp_pkg::ESC_VALUE) : x[3:0];
		cy = ey ? 4'(mp3hbp_pkg::ESC_VALUE) : y[3:0];
		rowprod = x[7:0] * tv;
		entry = (d_s1.table_sel < 6'd16) ? (rowprod[7:0] + y[7:0]) : {cx, cy};
		qn = 3'({2'd0, d_s1.quad_nonzero[3]} + {2'd0, d_s1.quad_nonzero[2]} +
			{2'd0, d_s1.quad_nonzero[1]} + {2'd0, d_s1.quad_nonzero[0]});
		// quad signs packed to the right, first value first
		qs = 4'd0;
		qsn = 3'd0;
		for (int i = 3; i >= 0; i--) begin
			if (d_s1.quad_nonzero[i]) begin
				qs = {qs[2:0], d_s1.sign_bits[i]};
				qsn = qsn + 3'd1;
			end
		end
		job = '0;
		if (d_s1.opcode == mp3hbp_pkg::OP_FLUSH) begin
			job.flush = 1'b1;
		end else if (d_s1.opcode == mp3hbp_pkg::OP_QUAD) begin
			job.has_code = 1'b1;
			job.nsign = {2'd0, qn};
			job.tail = {24'd0, qs};
			job.tail_n = {3'd0, qsn};
			entry = {4'd0, d_s1.quad_nonzero};
		end else begin
			job.has_code = 1'b1;
			job.nsign = {3'd0, 2'({1'b0, bx} + {1'b0, by})};
			// x linbits, x sign, y linbits, y sign
			if (ex) begin
				job.tail = (job.tail << lin) | (28'(xe) & ((28'd1 << lin) - 28'd1));
				job.tail_n = job.tail_n + {1'b0, lin};
			end
			if (bx) begin
				job.tail = {job.tail[26:0], d_s1.sign_bits[3]};
				job.tail_n = job.tail_n + 6'd1;
			end
			if (ey) begin
				job.tail = (job.tail << lin) | (28'(ye) & ((28'd1 << lin) - 28'd1));
				job.tail_n = job.tail_n + {1'b0, lin};
			end
			if (by) begin
				job.tail = {job.tail[26:0], d_s1.sign_bits[2]};
				job.tail_n = job.tail_n + 6'd1;
			end
		end
	end

	// stage 2: registered code store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			job_data <= job;
			job_code <= code_mem[ADDR_W'({d_s1.table_sel, entry})];
		end
	end
	assign job_valid = v_s2;

endmodule
`default_nettype wire

[hw/rtl/mp3hbp_queue.sv]
// ----------------------------------------------------------------------------
// mp3hbp_queue: short job queue
// Two-entry FIFO between the classifier and the packer.
// ----------------------------------------------------------------------------
`default_nettype none
module mp3hbp_queue (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              wr_valid,
	output logic             wr_ready,
	input  mp3hbp_pkg::job_t wr_job,
	input  wire [23:0]       wr_code,
	output logic             rd_valid,
	input  wire              rd_ready,
	output mp3hbp_pkg::job_t rd_job,
	output logic [23:0]      rd_code
);
	mp3hbp_pkg::job_t job_q [2];
	logic [23:0]      code_q [2];
	logic             wp_q, rp_q;
	logic [1:0]       cnt_q;
	logic             wr, rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;
	assign rd_job = job_q[rp_q];
	assign rd_code = code_q[rp_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end
	always_ff @(posedge clk) begin
		if (wr) begin
			job_q[wp_q] <= wr_job;
			code_q[wp_q] <= wr_code;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/mp3hbp_back.sv]
// ----------------------------------------------------------------------------
// mp3hbp_back: bit packer
// Joins pending bits, codeword and tail into one segment (a flush pads the
// pending bits to a whole byte), then sends it out one byte per cycle while
// the receiver accepts, via an output register; leftover bits stay pending.
`default_nettype none
module mp3hbp_back (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   job_valid,
	output logic                  job_ready,
	input  mp3hbp_pkg::job_t      job_data,
	input  wire [23:0]            job_code,
	output logic                  out_valid,
	input  wire                   out_ready,
	output mp3hbp_pkg::out_item_t out_data
);
	localparam int unsigned W = mp3hbp_pkg::SEG_W + 8;

	logic [6:0] pend_q;
	logic [2:0] pend_n_q;
	logic [W-1:0] seg_q;     // left-aligned bits still to send
	logic [2:0]   bytes_q;   // whole bytes left in seg_q
	logic         out_v_q;
	mp3hbp_pkg::out_item_t out_q;
	logic         busy;
	logic         can_out;

	assign can_out = !out_v_q || out_ready;
	assign busy = bytes_q != 3'd0;
	assign job_ready = !busy;
	assign out_valid = out_v_q;
	assign out_data = out_q;

	// build segment from job
	logic [4:0]  len;
	logic [4:0]  cn;
	logic [18:0] cw;
	logic [63:0] acc;
	logic [5:0]  accn;
	always_comb begin
		len = (job_code[23:19] > 5'(mp3hbp_pkg::MAX_LEN)) ? 5'(mp3hbp_pkg::MAX_LEN)
			: job_code[23:19];
		cn = (len > job_data.nsign) ? len - job_data.nsign : 5'd0;
		cw = job_code[18:0] & ((19'd1 << cn) - 19'd1);
		acc = {57'd0, pend_q} & ((64'd1 << pend_n_q) - 64'd1);
		accn = {3'd0, pend_n_q};
		if (job_data.flush) begin
			if (pend_n_q != 3'd0) begin
				acc = acc << (6'd8 - accn);
				accn = 6'd8;
			end
		end else begin
			acc = (acc << cn) | {45'd0, cw};
			accn = accn + {1'b0, cn};
			acc = (acc << job_data.tail_n) | {36'd0, job_data.tail};
			accn = accn + job_data.tail_n;
		end
	end

	// load on a new job, then shift one byte per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 7'd0;
			pend_n_q <= 3'd0;
			bytes_q <= 3'd0;
			out_v_q <= 1'b0;
		end else begin
			if (!busy && job_valid) begin
				bytes_q <= accn[5:3];
				pend_n_q <= accn[2:0];
				pend_q <= 7'(acc & ((64'd1 << accn[2:0]) - 64'd1));
			end else if (busy && can_out) begin
				bytes_q <= bytes_q - 3'd1;
			end
			if (busy && can_out)
				out_v_q <= 1'b1;
			else if (out_ready)
				out_v_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (!busy && job_valid)
			seg_q <= W'(acc >> accn[2:0]) << (W - 8 * accn[5:3]);
		else if (busy && can_out) begin
			out_q.out_byte <= seg_q[W-1 -: 8];
			out_q.last <= bytes_q == 3'd1;
			seg_q <= seg_q << 8;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/mp3_huffman_bit_packer.sv]
// ----------------------------------------------------------------------------
// mp3_huffman_bit_packer: MP3 Layer III Huffman bit packer
// Top level: classifier, job queue and byte packer.
// ----------------------------------------------------------------------------
// Usage: items enter on in_valid/in_ready as one in_item_t struct. Code and
// table loads write the stores and produce nothing. Pair, quad and flush
// items produce zero to six bytes on out_valid/out_ready, MSB-first, with
// last set on the final byte of each item.
// A transfer in passes the two classifier stages, the queue, the packer
// load and the output register before its first byte shows.
// The byte packer sets the rate: it loads a job, then sends one byte per
// cycle while the receiver accepts, and takes no new job until its last byte
// is in the output register. The front keeps accepting while the packer works,
// until the two-entry queue and its stages are full.
// Reset clears the pipeline valids, the queue and the pending bits; the code
// store and table values hold nothing defined until loaded.
// When the receiver stalls, the output register holds its byte and back
// pressure reaches in_ready through the queue.
// ----------------------------------------------------------------------------
`default_nettype none
module mp3_huffman_bit_packer #(
	parameter int unsigned TABLE_SLOTS = 34,
	parameter int unsigned ENTRIES_PER_TABLE = 256
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  mp3hbp_pkg::in_item_t  in_data,
	output logic                  out_valid,
	input  wire                   out_ready,
	output mp3hbp_pkg::out_item_t out_data
);
	logic             f_valid, f_ready, b_valid, b_ready;
	mp3hbp_pkg::job_t f_job, b_job;
	logic [23:0]      f_code, b_code;

	mp3hbp_front #(
		.TABLE_SLOTS(TABLE_SLOTS),
		.ENTRIES_PER_TABLE(ENTRIES_PER_TABLE)
	) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.job_valid(f_valid), .job_ready(f_ready), .job_data(f_job), .job_code(f_code)
	);

	mp3hbp_queue u_queue (
		.clk, .arst_n,
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_job(f_job), .wr_code(f_code),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_job(b_job), .rd_code(b_code)
	);

	mp3hbp_back u_back (
		.clk, .arst_n,
		.job_valid(b_valid), .job_ready(b_ready), .job_data(b_job), .job_code(b_code),
		.out_valid, .out_ready, .out_data
	);

endmodule
`default_nettype wire
